### rtl/core/sliding_window_rate_limiter_core_macros.svh
// assertion macros for the checker file
`ifndef SLIDING_WINDOW_RATE_LIMITER_CORE_MACROS_SVH
`define SLIDING_WINDOW_RATE_LIMITER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while arst_n is low
`define SWRL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while arst_n is low
`define SWRL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/swrl_pkg.sv
package swrl_pkg;

	// fixed field widths
	localparam int TIME_W   = 32;
	localparam int PERIOD_W = 16;
	localparam int BURST_W  = 5;
	localparam int CFG_W    = PERIOD_W;
	localparam int CFG_IDX_W = 1;

	// parameter defaults
	localparam int MAX_BURST_DEF  = 16;
	localparam int WAIT_DEPTH_DEF = 64;
	localparam int ID_BITS_DEF    = 8;

	// register reset values
	localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd1100;
	localparam logic [BURST_W-1:0]  BURST_RESET  = 5'd10;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PERIOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BURST  = 1'b1;

	// item opcodes
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

	typedef enum logic [1:0] {
		ST_GRANTED  = 2'd0,
		ST_QUEUED   = 2'd1,
		ST_REJECTED = 2'd2,
		ST_RELEASED = 2'd3
	} status_t;

	typedef enum logic [0:0] {
		ALU_ADD = 1'b0,
		ALU_SUB = 1'b1
	} alu_op_t;

	typedef struct packed {
		logic borrow;
		logic zero;
	} alu_flags_t;

endpackage

### rtl/core/swrl_ram.sv
module swrl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/swrl_alu.sv
module swrl_alu (
	input  swrl_pkg::alu_op_t                op,
	input  logic [swrl_pkg::TIME_W-1:0]      a,
	input  logic [swrl_pkg::TIME_W-1:0]      b,
	output logic [swrl_pkg::TIME_W-1:0]      res,
	output swrl_pkg::alu_flags_t             flags
);

	localparam int W = swrl_pkg::TIME_W;

	logic         is_sub;
	logic [W-1:0] b_op;
	logic [W:0]   sum;

	// subtract as a + ~b + 1, carry out clear means borrow
	assign is_sub = (op == swrl_pkg::ALU_SUB);
	assign b_op   = is_sub ? ~b : b;
	assign sum    = {1'b0, a} + {1'b0, b_op} + {{W{1'b0}}, is_sub};

	assign res          = sum[W-1:0];
	assign flags.borrow = is_sub & ~sum[W];
	assign flags.zero   = (sum[W-1:0] == '0);

endmodule

### rtl/core/sliding_window_rate_limiter_core.sv
// sliding window burst rate limiter
//
// input items: start with opcode and request_id; an item is taken at a rising
// edge where start is high and busy is low. opcode tick advances the
// millisecond clock, opcode request asks for a grant for request_id.
// results: valid is high for exactly one cycle per result item, with
// granted_id, status and last; the receiver cannot stall, so nothing waits.
// a request always gives one item (granted, queued or rejected), last set.
// a tick gives nothing unless the release timer expires, and then one released
// item per cycle, back to back, while ids wait and the log has room, the final
// one with last set. configuration: cfg_we, cfg_index, cfg_data, to be
// written only while idle; the block does not enforce it. sequencing: one
// shared 32-bit add/subtract unit under a sequencer, one operation per cycle.
// a request runs S_MUL, S_REQ (result registered), and S_SETTLE to S_TFIRE if
// it starts the timer. a tick runs S_MUL, S_INC, S_CHK; an expiry adds S_AGE,
// S_CMP if grants are logged, S_REL, and S_SETTLE to S_TFIRE if grants remain.
// reset: arst_n clears the clock, timer, both queues and loads the register
// defaults; the timestamp and id memories are left as they are.
module sliding_window_rate_limiter_core #(
	parameter int MAX_BURST  = swrl_pkg::MAX_BURST_DEF,
	parameter int WAIT_DEPTH = swrl_pkg::WAIT_DEPTH_DEF,
	parameter int ID_BITS    = swrl_pkg::ID_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic                           opcode,
	input  logic [ID_BITS-1:0]             request_id,
	input  logic                           cfg_we,
	input  logic [swrl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swrl_pkg::CFG_W-1:0]     cfg_data,
	output logic                           valid,
	output logic [ID_BITS-1:0]             granted_id,
	output logic [1:0]                     status,
	output logic                           last
);

	localparam int TW = swrl_pkg::TIME_W;
	localparam int PW = swrl_pkg::PERIOD_W;
	localparam int BW = swrl_pkg::BURST_W;
	// grant log index, grant count, wait index, wait count
	localparam int GB = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
	localparam int CB = $clog2(MAX_BURST + 1);
	localparam int WB = $clog2(WAIT_DEPTH);
	localparam int WC = $clog2(WAIT_DEPTH + 1);
	localparam int GS = CB + 1;
	localparam int WS = WC + 1;
	localparam int EW = (CB > BW) ? CB : BW;
	localparam int WW = PW + CB;

	typedef enum logic [12:0] {
		S_IDLE   = 13'b0000000000001,
		S_MUL    = 13'b0000000000010,
		S_REQ    = 13'b0000000000100,
		S_INC    = 13'b0000000001000,
		S_CHK    = 13'b0000000010000,
		S_AGE    = 13'b0000000100000,
		S_CMP    = 13'b0000001000000,
		S_REL    = 13'b0000010000000,
		S_SETTLE = 13'b0000100000000,
		S_TAGE   = 13'b0001000000000,
		S_TREM   = 13'b0010000000000,
		S_TMAX   = 13'b0100000000000,
		S_TFIRE  = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;

	// item and configuration
	logic               op_q;
	logic [ID_BITS-1:0] id_q;
	logic [PW-1:0]      period_q;
	logic [BW-1:0]      burst_q;

	// limiter state
	logic [TW-1:0] now_q;
	logic [TW-1:0] fire_q;
	logic          timer_q;
	logic [GB-1:0] ghead_q;
	logic [CB-1:0] gcount_q;
	logic [WB-1:0] whead_q;
	logic [WC-1:0] wcount_q;

	// working registers: window length and age / remainder / delay scratch
	logic [WW-1:0] window_q;
	logic [TW-1:0] acc_q;

	// result register
	logic               valid_q;
	logic [ID_BITS-1:0] out_id_q;
	swrl_pkg::status_t  status_q;
	logic               last_q;

	// derived control
	logic [EW-1:0] burst_ext;
	logic [CB-1:0] eff;
	logic [GS-1:0] gsum;
	logic [GB-1:0] gtail;
	logic [GB-1:0] ghead_nxt;
	logic [WS-1:0] wsum;
	logic [WB-1:0] wtail;
	logic [WB-1:0] whead_nxt;
	logic          grant_room;
	logic          wait_room;
	logic          rel_go;
	logic          rel_more;
	logic          g_we, g_adv, w_we, w_adv;
	logic [GB-1:0] g_raddr;
	logic [WB-1:0] w_raddr;
	logic [TW-1:0] g_rdata;
	logic [ID_BITS-1:0] w_rdata;

	// shared unit
	swrl_pkg::alu_op_t    alu_op;
	logic [TW-1:0]        alu_a, alu_b, alu_res;
	swrl_pkg::alu_flags_t alu_flags;
	logic                 alu_ge;

	// burst clamped to 1 .. MAX_BURST
	always_comb begin
		burst_ext = EW'(burst_q);
		if (burst_ext == '0) begin
			eff = CB'(1);
		end else if (burst_ext > EW'(MAX_BURST)) begin
			eff = CB'(MAX_BURST);
		end else begin
			eff = CB'(burst_ext);
		end
	end

	// ring positions, wrapping at the depth
	always_comb begin
		gsum = GS'(ghead_q) + GS'(gcount_q);
		if (gsum >= GS'(MAX_BURST)) begin
			gsum = gsum - GS'(MAX_BURST);
		end
		wsum = WS'(whead_q) + WS'(wcount_q);
		if (wsum >= WS'(WAIT_DEPTH)) begin
			wsum = wsum - WS'(WAIT_DEPTH);
		end
	end

	assign gtail     = gsum[GB-1:0];
	assign wtail     = wsum[WB-1:0];
	assign ghead_nxt = (ghead_q == GB'(MAX_BURST - 1)) ? '0 : ghead_q + GB'(1);
	assign whead_nxt = (whead_q == WB'(WAIT_DEPTH - 1)) ? '0 : whead_q + WB'(1);

	assign grant_room = (gcount_q < eff);
	assign wait_room  = (wcount_q < WC'(WAIT_DEPTH));
	assign rel_go     = grant_room && (wcount_q != '0);
	// another release follows this one in the next cycle
	assign rel_more   = ((GS'(gcount_q) + GS'(1)) < GS'(eff)) && (wcount_q > WC'(1));

	// operand selection for the shared add/subtract unit
	always_comb begin
		alu_op = swrl_pkg::ALU_ADD;
		alu_a  = '0;
		alu_b  = '0;
		unique case (state_q)
			S_INC: begin
				alu_a = now_q;
				alu_b = TW'(1);
			end
			S_CHK: begin
				alu_op = swrl_pkg::ALU_SUB;
				alu_a  = now_q;
				alu_b  = fire_q;
			end
			S_AGE, S_TAGE: begin
				// age of the oldest logged grant, modulo 2^32
				alu_op = swrl_pkg::ALU_SUB;
				alu_a  = now_q;
				alu_b  = g_rdata;
			end
			S_CMP, S_TREM: begin
				// window - age: borrow or zero means the age reached the window
				alu_op = swrl_pkg::ALU_SUB;
				alu_a  = TW'(window_q);
				alu_b  = acc_q;
			end
			S_TMAX: begin
				alu_op = swrl_pkg::ALU_SUB;
				alu_a  = acc_q;
				alu_b  = TW'(period_q);
			end
			S_TFIRE: begin
				alu_a = now_q;
				alu_b = acc_q;
			end
			default: begin
				alu_op = swrl_pkg::ALU_ADD;
			end
		endcase
	end

	assign alu_ge = alu_flags.borrow | alu_flags.zero;

	swrl_alu u_alu (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.res   (alu_res),
		.flags (alu_flags)
	);

	// sequencer next state and memory strobes
	always_comb begin
		state_d = state_q;
		g_we    = 1'b0;
		g_adv   = 1'b0;
		w_we    = 1'b0;
		w_adv   = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = (op_q == swrl_pkg::OP_TICK) ? S_INC : S_REQ;
			end
			S_REQ: begin
				if (grant_room) begin
					g_we = 1'b1;
				end else if (wait_room) begin
					w_we = 1'b1;
				end
				// first grant in an empty log arms the timer
				if (!timer_q && (grant_room || gcount_q != '0)) begin
					state_d = S_SETTLE;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_INC: begin
				state_d = S_CHK;
			end
			S_CHK: begin
				if (timer_q && alu_flags.zero) begin
					state_d = (gcount_q != '0) ? S_AGE : S_REL;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_AGE: begin
				state_d = S_CMP;
			end
			S_CMP: begin
				// drop the oldest grant once it has aged out of the window
				g_adv   = alu_ge;
				state_d = S_REL;
			end
			S_REL: begin
				if (rel_go) begin
					w_adv = 1'b1;
					g_we  = 1'b1;
				end else begin
					state_d = (gcount_q != '0) ? S_SETTLE : S_IDLE;
				end
			end
			S_SETTLE: begin
				// lets the head timestamp read catch up with the last write
				state_d = S_TAGE;
			end
			S_TAGE: begin
				state_d = S_TREM;
			end
			S_TREM: begin
				state_d = S_TMAX;
			end
			S_TMAX: begin
				state_d = S_TFIRE;
			end
			S_TFIRE: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// read addresses look one entry ahead when the head moves
	assign g_raddr = g_adv ? ghead_nxt : ghead_q;
	assign w_raddr = w_adv ? whead_nxt : whead_q;

	// grant timestamp log
	swrl_ram #(
		.WIDTH (TW),
		.DEPTH (MAX_BURST)
	) u_grant_ram (
		.clk   (clk),
		.we    (g_we),
		.waddr (gtail),
		.wdata (now_q),
		.raddr (g_raddr),
		.rdata (g_rdata)
	);

	// waiting id fifo
	swrl_ram #(
		.WIDTH (ID_BITS),
		.DEPTH (WAIT_DEPTH)
	) u_wait_ram (
		.clk   (clk),
		.we    (w_we),
		.waddr (wtail),
		.wdata (id_q),
		.raddr (w_raddr),
		.rdata (w_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			period_q <= swrl_pkg::PERIOD_RESET;
			burst_q  <= swrl_pkg::BURST_RESET;
			now_q    <= '0;
			fire_q   <= '0;
			timer_q  <= 1'b0;
			ghead_q  <= '0;
			gcount_q <= '0;
			whead_q  <= '0;
			wcount_q <= '0;
			valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			valid_q <= 1'b0;
			if (cfg_we) begin
				unique case (cfg_index)
					swrl_pkg::REG_PERIOD: period_q <= cfg_data;
					swrl_pkg::REG_BURST:  burst_q  <= cfg_data[BW-1:0];
					default: ;
				endcase
			end
			unique case (state_q)
				S_REQ: begin
					valid_q <= 1'b1;
					if (grant_room) begin
						gcount_q <= gcount_q + CB'(1);
					end else if (wait_room) begin
						wcount_q <= wcount_q + WC'(1);
					end
				end
				S_INC: begin
					now_q <= alu_res;
				end
				S_CMP: begin
					if (alu_ge) begin
						ghead_q  <= ghead_nxt;
						gcount_q <= gcount_q - CB'(1);
					end
				end
				S_REL: begin
					if (rel_go) begin
						valid_q  <= 1'b1;
						whead_q  <= whead_nxt;
						wcount_q <= wcount_q - WC'(1);
						gcount_q <= gcount_q + CB'(1);
					end else if (gcount_q == '0) begin
						timer_q <= 1'b0;
					end
				end
				S_TFIRE: begin
					fire_q  <= alu_res;
					timer_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	// item capture, working registers and result payload
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					op_q <= opcode;
					id_q <= request_id;
				end
			end
			S_MUL: begin
				window_q <= WW'(period_q) * WW'(eff);
			end
			S_REQ: begin
				out_id_q <= id_q;
				last_q   <= 1'b1;
				if (grant_room) begin
					status_q <= swrl_pkg::ST_GRANTED;
				end else if (wait_room) begin
					status_q <= swrl_pkg::ST_QUEUED;
				end else begin
					status_q <= swrl_pkg::ST_REJECTED;
				end
			end
			S_AGE, S_TAGE: begin
				acc_q <= alu_res;
			end
			S_TREM: begin
				// remaining time clamps at zero once the head is past the window
				acc_q <= alu_ge ? '0 : alu_res;
			end
			S_TMAX: begin
				// delay is the larger of remainder and period, at least one tick
				if (alu_flags.borrow) begin
					acc_q <= (period_q == '0) ? TW'(1) : TW'(period_q);
				end else begin
					acc_q <= (acc_q == '0) ? TW'(1) : acc_q;
				end
			end
			S_REL: begin
				if (rel_go) begin
					out_id_q <= w_rdata;
					status_q <= swrl_pkg::ST_RELEASED;
					last_q   <= !rel_more;
				end
			end
			default: ;
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign valid      = valid_q;
	assign granted_id = out_id_q;
	assign status     = status_q;
	assign last       = last_q;

endmodule

### rtl/core/swrl_checker.sv
`include "sliding_window_rate_limiter_core_macros.svh"

module swrl_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       valid,
	input logic [1:0] status,
	input logic       last
);

	// an accepted item always makes the block busy
	`SWRL_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")

	// busy only ever rises from an accepted item
	`SWRL_ASSERT_NOW(a_busy_from_start, $rose(busy), $past(start), "busy rose without start")

	// request results come alone
	`SWRL_ASSERT_NOW(a_req_single, valid && (status != swrl_pkg::ST_RELEASED), last, "request result without last")

	// releases run back to back until the one marked last
	`SWRL_ASSERT_NEXT(a_rel_chain, valid && !last, valid && (status == swrl_pkg::ST_RELEASED), "release chain broken")

endmodule

bind sliding_window_rate_limiter_core swrl_checker u_swrl_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.valid  (valid),
	.status (status),
	.last   (last)
);
